// ===== rtl/block_range_translation_table_unit_assert.svh =====
// Assertion macros for the block range translation table unit.
`ifndef BLOCK_RANGE_TRANSLATION_TABLE_UNIT_ASSERT_SVH
`define BLOCK_RANGE_TRANSLATION_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BRTT_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BRTT_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/brtt_pkg.sv =====
// Shared types and codes of the block range translation table.
package brtt_pkg;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_REMOVE,
		OP_LOOKUP,
		OP_COUNT
	} op_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_TAIL,
		ST_NOBLK,
		ST_NOTFOUND,
		ST_FULL,
		ST_NONE
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ADD_START,
		S_ADD_DIV,
		S_ADD_CHK,
		S_ADD_GO,
		S_ADD_WAIT,
		S_REM_SCAN,
		S_REM_CHK,
		S_FIND_SCAN,
		S_LO_GO,
		S_LO_WAIT,
		S_HI_GO,
		S_HI_WAIT,
		S_REM_WR,
		S_REM_SPLIT,
		S_LK_SCAN,
		S_LK_GO,
		S_LK_WAIT,
		S_EMIT
	} state_t;

endpackage

// ===== rtl/brtt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module brtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/brtt_div.sv =====
// Restoring divider, one quotient bit per cycle.
module brtt_div #(
	parameter int DW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [31:0]   divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int CNTW = $clog2(DW + 1);

	logic [32:0]     rem_q;
	logic [DW-1:0]   quo_q;
	logic [31:0]     div_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [32:0]     rem_sh;
	logic            ge;

	assign rem_sh   = {rem_q[31:0], quo_q[DW-1]};
	assign ge       = rem_sh >= {1'b0, div_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNTW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? rem_sh - {1'b0, div_q} : rem_sh;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end
endmodule

// ===== rtl/brtt_mac.sv =====
// Shared multiply-add: result = base + a * b, truncated to the offset width.
module brtt_mac #(
	parameter int OB = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [OB-1:0] base,
	input  logic [31:0]   mul_a,
	input  logic [31:0]   mul_b,
	output logic          done,
	output logic [OB-1:0] result
);
	logic [63:0]   prod_s1;
	logic [OB-1:0] base_s1;
	logic          v_s1;
	logic          done_q;
	logic [OB-1:0] res_q;

	assign done   = done_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(mul_a) * 64'(mul_b);
		base_s1 <= base;
		res_q   <= base_s1 + prod_s1[OB-1:0];
	end
endmodule

// ===== rtl/block_range_translation_table_unit.sv =====
// Top level of the block range translation table: sequencer, table and shared units.
//
//  channel   dir  handshake                     contents
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser opcode; tdata tag, offsets, block span
//  m_axis    out  m_axis_tvalid/m_axis_tready   tuser status; tdata tag, offsets, ids, total
//  cfg       in   cfg_we                        bytes per block
//
// One item at a time; s_axis_tready is high only when the sequencer is idle.
// Add: the bit-serial divider finds the block count, then the multiply-add the end offset.
// Remove: a summing scan, then per freed piece one table scan and two passes through
// the multiply-add. Lookup: one table scan, then the multiply-add on a hit.
// A count query goes straight to the output state.
// Reset clears valid bits, counters and sets the bytes-per-block register to 4096;
// no clearing pass. A stalled result holds the sequencer in its output state.
module block_range_translation_table_unit #(
	parameter int TABLE_ENTRIES = 16,
	parameter int OFFSET_BITS   = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// opcode
	input  logic [1:0] s_axis_tuser,
	// storage_tag, offset_begin, offset_end, block_lo, block_hi
	input  logic [((96+2*OFFSET_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// status
	output logic [2:0] m_axis_tuser,
	// tag_out, offset_lo_out, offset_hi_out, first_block_out,
	// block_count_out, total_blocks
	output logic [((128+2*OFFSET_BITS+7)/8)*8-1:0] m_axis_tdata,
	output logic m_axis_tlast
);
	import brtt_pkg::*;

	localparam int OB  = OFFSET_BITS;
	localparam int N   = TABLE_ENTRIES;
	localparam int IW  = $clog2(N);
	localparam int CW  = $clog2(N + 1);
	localparam int EW  = 96 + 2 * OB;
	localparam int OPW = ((128 + 2 * OB + 7) / 8) * 8;
	localparam int QW  = (OB > 32) ? OB : 32;

	state_t state_q, state_d;

	logic [31:0]   bs_q;
	logic [N-1:0]  valid_q;
	logic [31:0]   next_q;
	logic [31:0]   mapped_q;
	logic [CW-1:0] scan_idx_q;
	logic          rd_v_s1;
	logic [IW-1:0] rd_idx_s1;

	logic [1:0]    op_in;
	logic [31:0]   tag_in_q;
	logic [OB-1:0] ob_q, oe_q;
	logic [31:0]   lo_q, hi_q, cur_q;
	logic [31:0]   n_q, sum_q;
	logic [CW-1:0] pieces_q;
	logic          split_q, found_q;
	logic [IW-1:0] best_idx_q;
	logic [EW-1:0] best_q;
	logic [OB-1:0] flo_q, fhi_q;

	logic [2:0]    st_o;
	logic [31:0]   tag_o, first_o, cnt_o;
	logic [OB-1:0] lo_o, hi_o;
	logic          last_o;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	logic          div_go, div_done;
	logic [OB-1:0] div_q_out, size;
	logic          mac_go, mac_done;
	logic [OB-1:0] mac_base, mac_res;
	logic [31:0]   mac_a;

	logic          acc, scanning, scan_done, hit, ov;
	logic [31:0]   eb, ee, xb, xe;
	logic [31:0]   bb, be, ib, ie;
	logic          free_any;
	logic [IW-1:0] free_idx;
	logic [31:0]   n_clamp;
	logic [31:0]   room;

	assign op_in = s_axis_tuser;
	assign acc   = s_axis_tvalid && s_axis_tready;

	assign scanning  = (state_q == S_REM_SCAN) || (state_q == S_FIND_SCAN) ||
	                   (state_q == S_LK_SCAN);
	assign scan_done = (scan_idx_q == CW'(N)) && !rd_v_s1;

	assign eb  = ram_rdata[31:0];
	assign ee  = ram_rdata[63:32];
	assign hit = rd_v_s1 && valid_q[rd_idx_s1];
	assign xb  = (eb > cur_q) ? eb : cur_q;
	assign xe  = (ee < hi_q) ? ee : hi_q;
	assign ov  = hit && (xb < xe);

	assign bb = best_q[31:0];
	assign be = best_q[63:32];
	assign ib = (bb > cur_q) ? bb : cur_q;
	assign ie = (be < hi_q) ? be : hi_q;

	assign size = (oe_q > ob_q) ? oe_q - ob_q : '0;
	assign room = ~next_q;
	assign n_clamp = (QW'(div_q_out) > QW'(room)) ? room : 32'(div_q_out);

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IW'(i);
			end
		end
	end
	assign free_any = ~&valid_q;

	brtt_ram #(.WIDTH(EW), .DEPTH(N)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (scan_idx_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	brtt_div #(.DW(OB)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (size),
		.divisor  (bs_q),
		.done     (div_done),
		.quotient (div_q_out)
	);

	brtt_mac #(.OB(OB)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_go),
		.base   (mac_base),
		.mul_a  (mac_a),
		.mul_b  (bs_q),
		.done   (mac_done),
		.result (mac_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (op_t'(op_in))
						OP_ADD:    state_d = S_ADD_START;
						OP_REMOVE: state_d = S_REM_SCAN;
						OP_LOOKUP: state_d = S_LK_SCAN;
						default:   state_d = S_EMIT;
					endcase
				end
			end
			S_ADD_START: state_d = (bs_q == '0) ? S_ADD_CHK : S_ADD_DIV;
			S_ADD_DIV:   if (div_done) state_d = S_ADD_CHK;
			S_ADD_CHK:   state_d = (n_q == '0 || !free_any) ? S_EMIT : S_ADD_GO;
			S_ADD_GO:    state_d = S_ADD_WAIT;
			S_ADD_WAIT:  if (mac_done) state_d = S_EMIT;
			S_REM_SCAN:  if (scan_done) state_d = S_REM_CHK;
			S_REM_CHK: begin
				if ((split_q && !free_any) || pieces_q == '0) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_FIND_SCAN;
				end
			end
			S_FIND_SCAN: if (scan_done) state_d = S_LO_GO;
			S_LO_GO:     state_d = S_LO_WAIT;
			S_LO_WAIT:   if (mac_done) state_d = S_HI_GO;
			S_HI_GO:     state_d = S_HI_WAIT;
			S_HI_WAIT:   if (mac_done) state_d = S_REM_WR;
			S_REM_WR:    state_d = (bb < ib && ie < be) ? S_REM_SPLIT : S_EMIT;
			S_REM_SPLIT: state_d = S_EMIT;
			S_LK_SCAN:   if (scan_done) state_d = found_q ? S_LK_GO : S_EMIT;
			S_LK_GO:     state_d = S_LK_WAIT;
			S_LK_WAIT:   if (mac_done) state_d = S_EMIT;
			S_EMIT: begin
				if (m_axis_tready) begin
					state_d = last_o ? S_IDLE : S_FIND_SCAN;
				end
			end
			default:     state_d = S_IDLE;
		endcase
	end

	// control strobes and table writes
	always_comb begin
		s_axis_tready = (state_q == S_IDLE);
		m_axis_tvalid = (state_q == S_EMIT);
		div_go        = (state_q == S_ADD_START) && (bs_q != '0);
		mac_go        = (state_q == S_ADD_GO) || (state_q == S_LO_GO) ||
		                (state_q == S_HI_GO) || (state_q == S_LK_GO);
		mac_base      = best_q[96+OB-1:96];
		mac_a         = ib - bb;
		ram_we        = 1'b0;
		ram_waddr     = best_idx_q;
		ram_wdata     = best_q;
		case (state_q)
			S_ADD_GO: begin
				mac_base = ob_q;
				mac_a    = n_q;
			end
			S_HI_GO: mac_a = ie - bb;
			S_LK_GO: mac_a = lo_q - bb;
			S_ADD_WAIT: begin
				ram_we    = mac_done;
				ram_waddr = free_idx;
				ram_wdata = {mac_res, ob_q, tag_in_q, next_q + n_q, next_q};
			end
			S_REM_WR: begin
				if (bb < ib) begin
					ram_we    = 1'b1;
					ram_wdata = {flo_q, best_q[96+OB-1:64], ib, bb};
				end else if (ie < be) begin
					ram_we    = 1'b1;
					ram_wdata = {best_q[EW-1:96+OB], fhi_q, best_q[95:64], be, ie};
				end
			end
			S_REM_SPLIT: begin
				ram_we    = free_any;
				ram_waddr = free_idx;
				ram_wdata = {best_q[EW-1:96+OB], fhi_q, best_q[95:64], be, ie};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			bs_q       <= 32'd4096;
			valid_q    <= '0;
			next_q     <= '0;
			mapped_q   <= '0;
			scan_idx_q <= '0;
			rd_v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				bs_q <= cfg_wdata;
			end
			rd_v_s1 <= scanning && (scan_idx_q != CW'(N));
			if (!scanning) begin
				scan_idx_q <= '0;
			end else if (scan_idx_q != CW'(N)) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			case (state_q)
				S_ADD_WAIT: begin
					if (mac_done) begin
						valid_q[free_idx] <= 1'b1;
						next_q            <= next_q + n_q;
						mapped_q          <= mapped_q + n_q;
					end
				end
				S_REM_CHK: begin
					if (!(split_q && !free_any) && pieces_q != '0) begin
						mapped_q <= mapped_q - sum_q;
					end
				end
				S_REM_WR: begin
					// drop an entry that the span covers whole
					if (!(bb < ib) && !(ie < be)) begin
						valid_q[best_idx_q] <= 1'b0;
					end
				end
				S_REM_SPLIT: begin
					if (free_any) begin
						valid_q[free_idx] <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q[IW-1:0];
		if (!scanning) begin
			found_q <= 1'b0;
		end
		case (state_q)
			S_IDLE: begin
				tag_in_q <= s_axis_tdata[31:0];
				ob_q     <= s_axis_tdata[32+OB-1:32];
				oe_q     <= s_axis_tdata[32+2*OB-1:32+OB];
				lo_q     <= s_axis_tdata[32+2*OB+31:32+2*OB];
				hi_q     <= s_axis_tdata[32+2*OB+63:32+2*OB+32];
				cur_q    <= s_axis_tdata[32+2*OB+31:32+2*OB];
				sum_q    <= '0;
				pieces_q <= '0;
				split_q  <= 1'b0;
				st_o     <= ST_OK;
				tag_o    <= '0;
				lo_o     <= '0;
				hi_o     <= '0;
				first_o  <= '0;
				cnt_o    <= '0;
				last_o   <= 1'b1;
			end
			S_ADD_START: n_q <= '0;
			S_ADD_DIV:   if (div_done) n_q <= n_clamp;
			S_ADD_CHK: begin
				st_o    <= (n_q == '0) ? ST_NOBLK : ST_FULL;
				tag_o   <= tag_in_q;
				lo_o    <= ob_q;
				hi_o    <= oe_q;
				first_o <= '0;
				cnt_o   <= '0;
			end
			S_ADD_WAIT: begin
				st_o    <= (mac_res < oe_q) ? ST_TAIL : ST_OK;
				lo_o    <= mac_res;
				first_o <= next_q;
				cnt_o   <= n_q;
			end
			S_REM_SCAN: begin
				if (ov) begin
					sum_q    <= sum_q + (xe - xb);
					pieces_q <= pieces_q + 1'b1;
				end
				if (hit && lo_q < hi_q && eb < lo_q && ee > hi_q) begin
					split_q <= 1'b1;
				end
			end
			S_REM_CHK: begin
				st_o <= (split_q && !free_any) ? ST_FULL : ST_NONE;
			end
			S_FIND_SCAN: begin
				if (ov && (!found_q || eb < bb)) begin
					found_q    <= 1'b1;
					best_idx_q <= rd_idx_s1;
					best_q     <= ram_rdata;
				end
			end
			S_LO_WAIT: if (mac_done) flo_q <= mac_res;
			S_HI_WAIT: if (mac_done) fhi_q <= mac_res;
			S_REM_WR: begin
				st_o     <= ST_OK;
				tag_o    <= best_q[95:64];
				lo_o     <= flo_q;
				hi_o     <= fhi_q;
				first_o  <= ib;
				cnt_o    <= ie - ib;
				last_o   <= (pieces_q == CW'(1));
				pieces_q <= pieces_q - 1'b1;
				cur_q    <= be;
			end
			S_LK_SCAN: begin
				st_o <= ST_NOTFOUND;
				if (hit && eb <= lo_q && lo_q < ee) begin
					found_q    <= 1'b1;
					best_idx_q <= rd_idx_s1;
					best_q     <= ram_rdata;
				end
			end
			S_LK_WAIT: begin
				if (mac_done) begin
					st_o  <= ST_OK;
					tag_o <= best_q[95:64];
					lo_o  <= mac_res;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tdata = OPW'({mapped_q, cnt_o, first_o, hi_o, lo_o, tag_o});
	assign m_axis_tuser = st_o;
	assign m_axis_tlast = last_o;

`include "block_range_translation_table_unit_assert.svh"

	`BRTT_ASSERT_IMP(a_one_item, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
	`BRTT_ASSERT_NXT(a_busy_after_accept, acc, !s_axis_tready, "ready right after accept")
	`BRTT_ASSERT_IMP(a_div_owner, div_done, state_q == S_ADD_DIV, "divider done outside add")
	`BRTT_ASSERT_IMP(a_mac_owner, mac_done, state_q == S_ADD_WAIT || state_q == S_LO_WAIT || state_q == S_HI_WAIT || state_q == S_LK_WAIT, "multiply-add done while not waited for")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the block range translation table unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import brtt_pkg::*;

	localparam int ENTRIES = 16;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		op_t         op;
		logic [31:0] tag;
		logic [47:0] ob;
		logic [47:0] oe;
		logic [31:0] lo;
		logic [31:0] hi;
	} cmd_t;

	typedef struct {
		status_t     st;
		logic [31:0] tag;
		logic [47:0] olo;
		logic [47:0] ohi;
		logic [31:0] first;
		logic [31:0] cnt;
		logic [31:0] total;
		logic        last;
	} resp_t;

	typedef struct {
		cmd_t  c;
		bit    typed;
		resp_t r;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [31:0] cfg_wdata = '0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [1:0] s_axis_tuser = '0;
	logic [191:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [2:0] m_axis_tuser;
	logic [223:0] m_axis_tdata;
	logic m_axis_tlast;

	block_range_translation_table_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tuser(m_axis_tuser), .m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// table image
	logic [31:0] blk_size;
	bit          tv [ENTRIES];
	logic [31:0] tb_beg [ENTRIES];
	logic [31:0] tb_end [ENTRIES];
	logic [31:0] ttag [ENTRIES];
	logic [47:0] tob [ENTRIES];
	logic [47:0] toe [ENTRIES];
	logic [31:0] next_id;
	logic [31:0] mapped;

	resp_t pending_q[$];
	bit failed = 0;
	bit calm = 0;
	int hold_req = 0;

	function automatic int free_entry();
		for (int i = 0; i < ENTRIES; i++)
			if (!tv[i]) return i;
		return -1;
	endfunction

	function automatic logic [47:0] byte_off(int e, logic [31:0] id);
		logic [63:0] d;
		d = 64'(id - tb_beg[e]);
		return 48'(64'(tob[e]) + d * 64'(blk_size));
	endfunction

	function automatic resp_t mk_resp(status_t st, logic [31:0] tag, logic [47:0] lo,
			logic [47:0] hi, logic [31:0] first, logic [31:0] cnt);
		resp_t r;
		r.st = st; r.tag = tag; r.olo = lo; r.ohi = hi;
		r.first = first; r.cnt = cnt; r.total = 0; r.last = 0;
		return r;
	endfunction

	// compute the results of one item and update the table image
	function automatic void translate(cmd_t c);
		resp_t out[$];
		logic [63:0] sz, n, room, used;
		logic [31:0] cur, b, e, ib, ie, xb, xe;
		logic [47:0] flo, fhi;
		int s, best;
		bit split, go;
		case (c.op)
			OP_ADD: begin
				sz = c.oe > c.ob ? 64'(c.oe) - 64'(c.ob) : 0;
				n = blk_size != 0 ? sz / 64'(blk_size) : 0;
				room = 64'hFFFF_FFFF - 64'(next_id);
				if (n > room) n = room;
				s = free_entry();
				if (n == 0) out.push_back(mk_resp(ST_NOBLK, c.tag, c.ob, c.oe, 0, 0));
				else if (s < 0) out.push_back(mk_resp(ST_FULL, c.tag, c.ob, c.oe, 0, 0));
				else begin
					used = 64'(48'(64'(c.ob) + n * 64'(blk_size)));
					tv[s] = 1; tb_beg[s] = next_id; tb_end[s] = next_id + 32'(n);
					ttag[s] = c.tag; tob[s] = c.ob; toe[s] = 48'(used);
					out.push_back(mk_resp(48'(used) < c.oe ? ST_TAIL : ST_OK, c.tag,
						48'(used), c.oe, next_id, 32'(n)));
					next_id += 32'(n);
					mapped += 32'(n);
				end
			end
			OP_REMOVE: begin
				split = 0;
				if (c.lo < c.hi)
					for (int i = 0; i < ENTRIES; i++)
						if (tv[i] && tb_beg[i] < c.lo && tb_end[i] > c.hi) split = 1;
				if (split && free_entry() < 0)
					out.push_back(mk_resp(ST_FULL, 0, 0, 0, 0, 0));
				else begin
					cur = c.lo;
					go = 1;
					while (go) begin
						best = -1;
						for (int i = 0; i < ENTRIES; i++) begin
							if (!tv[i]) continue;
							xb = tb_beg[i] > cur ? tb_beg[i] : cur;
							xe = tb_end[i] < c.hi ? tb_end[i] : c.hi;
							if (xb < xe && (best < 0 || tb_beg[i] < tb_beg[best])) best = i;
						end
						if (best < 0 || out.size() >= ENTRIES) go = 0;
						else begin
							b = tb_beg[best]; e = tb_end[best];
							ib = b > cur ? b : cur;
							ie = e < c.hi ? e : c.hi;
							flo = byte_off(best, ib);
							fhi = byte_off(best, ie);
							out.push_back(mk_resp(ST_OK, ttag[best], flo, fhi, ib, ie - ib));
							if (b < ib && ie < e) begin
								s = free_entry();
								if (s >= 0) begin
									tv[s] = 1; tb_beg[s] = ie; tb_end[s] = e;
									ttag[s] = ttag[best]; tob[s] = fhi; toe[s] = toe[best];
								end
								tb_end[best] = ib; toe[best] = flo;
							end else if (b < ib) begin
								tb_end[best] = ib; toe[best] = flo;
							end else if (ie < e) begin
								tb_beg[best] = ie; tob[best] = fhi;
							end else
								tv[best] = 0;
							mapped -= ie - ib;
							cur = e;
						end
					end
					if (out.size() == 0) out.push_back(mk_resp(ST_NONE, 0, 0, 0, 0, 0));
				end
			end
			OP_LOOKUP: begin
				best = -1;
				for (int i = 0; i < ENTRIES; i++)
					if (best < 0 && tv[i] && tb_beg[i] <= c.lo && c.lo < tb_end[i]) best = i;
				if (best < 0) out.push_back(mk_resp(ST_NOTFOUND, 0, 0, 0, 0, 0));
				else out.push_back(mk_resp(ST_OK, ttag[best], byte_off(best, c.lo), 0, 0, 0));
			end
			default: out.push_back(mk_resp(ST_OK, 0, 0, 0, 0, 0));
		endcase
		foreach (out[k]) begin
			out[k].total = mapped;
			out[k].last = (k == out.size() - 1);
			pending_q.push_back(out[k]);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (calm || r < 55) return 0;
		if (r < 93) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	task automatic send(cmd_t c, int gap);
		@(negedge clk);
		s_axis_tvalid <= 1;
		s_axis_tuser <= c.op;
		s_axis_tdata <= {c.hi, c.lo, c.oe, c.ob, c.tag};
		do @(posedge clk); while (!s_axis_tready);
		translate(c);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drop_valid();
		if (s_axis_tvalid) begin
			@(negedge clk);
			s_axis_tvalid <= 0;
		end
	endtask

	task automatic drain();
		drop_valid();
		wait (pending_q.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_bsize(logic [31:0] v);
		drain();
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		blk_size = v;
	endtask

	function automatic cmd_t mk_cmd(op_t op, logic [31:0] tag, logic [47:0] ob,
			logic [47:0] oe, logic [31:0] lo, logic [31:0] hi);
		cmd_t c;
		c.op = op; c.tag = tag; c.ob = ob; c.oe = oe; c.lo = lo; c.hi = hi;
		return c;
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int r;
		logic [63:0] nb;
		c.op = OP_COUNT;
		c.tag = $urandom;
		c.ob = {16'($urandom), 32'($urandom)};
		c.oe = c.ob;
		c.lo = $urandom;
		c.hi = $urandom;
		r = $urandom_range(99);
		if (r < 38) begin
			c.op = OP_ADD;
			nb = $urandom_range(5);
			if ($urandom_range(9) == 0) c.oe = {16'($urandom), 32'($urandom)};
			else c.oe = 48'(64'(c.ob) + nb * 64'(blk_size) + 64'($urandom) % 64'(blk_size));
		end else if (r < 68) begin
			c.op = OP_REMOVE;
			if ($urandom_range(9) != 0) begin
				c.lo = $urandom_range(next_id + 2);
				c.hi = $urandom_range(9) == 0 ? c.lo - $urandom_range(3)
					: c.lo + $urandom_range(8);
			end
		end else if (r < 92) begin
			c.op = OP_LOOKUP;
			if ($urandom_range(9) != 0) c.lo = $urandom_range(next_id + 1);
		end
		return c;
	endfunction

	// result checker and receiver idling
	int stall_left = 0;
	always @(negedge clk) begin
		if (hold_req > 0) begin
			m_axis_tready <= 0;
			hold_req <= hold_req - 1;
		end else if (stall_left > 0) begin
			m_axis_tready <= 0;
			stall_left <= stall_left - 1;
		end else begin
			m_axis_tready <= 1;
			if (!calm && $urandom_range(3) == 0)
				stall_left <= $urandom_range(9) == 0 ? $urandom_range(60, 20)
					: $urandom_range(3, 1);
		end
	end

	always @(posedge clk) begin
		resp_t w;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_q.size() == 0) begin
				$error("result with none expected");
				failed = 1;
			end else begin
				w = pending_q.pop_front();
				if (m_axis_tuser !== w.st) begin
					$error("status exp %0d got %0d", w.st, m_axis_tuser); failed = 1;
				end
				if (m_axis_tdata[31:0] !== w.tag) begin
					$error("tag_out exp %h got %h", w.tag, m_axis_tdata[31:0]); failed = 1;
				end
				if (m_axis_tdata[79:32] !== w.olo) begin
					$error("offset_lo_out exp %h got %h", w.olo, m_axis_tdata[79:32]);
					failed = 1;
				end
				if (m_axis_tdata[127:80] !== w.ohi) begin
					$error("offset_hi_out exp %h got %h", w.ohi, m_axis_tdata[127:80]);
					failed = 1;
				end
				if (m_axis_tdata[159:128] !== w.first) begin
					$error("first_block_out exp %h got %h", w.first, m_axis_tdata[159:128]);
					failed = 1;
				end
				if (m_axis_tdata[191:160] !== w.cnt) begin
					$error("block_count_out exp %h got %h", w.cnt, m_axis_tdata[191:160]);
					failed = 1;
				end
				if (m_axis_tdata[223:192] !== w.total) begin
					$error("total_blocks exp %h got %h", w.total, m_axis_tdata[223:192]);
					failed = 1;
				end
				if (m_axis_tlast !== w.last) begin
					$error("last exp %b got %b", w.last, m_axis_tlast); failed = 1;
				end
			end
		end
	end

	// end the run when nothing moves for too long
	int quiet = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			quiet <= 0;
		else if (quiet >= IDLE_LIMIT) begin
			$display("** block_range_translation_table_unit: FAILED **");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	row_t rows[$];
	logic [31:0] sizes [5] = '{32'd1, 32'd16, 32'd4096, 32'hFFFF_FFFF, 32'd7};

	function automatic row_t mk_row(cmd_t c, bit typed, resp_t r);
		row_t x;
		x.c = c; x.typed = typed; x.r = r; x.r.last = 1;
		return x;
	endfunction

	initial begin
		resp_t none;
		none = mk_resp(ST_OK, 0, 0, 0, 0, 0);
		blk_size = 4096;
		next_id = 0;
		mapped = 0;
		foreach (tv[i]) tv[i] = 0;

		rows.push_back(mk_row(mk_cmd(OP_COUNT, 0, 0, 0, 0, 0), 1, none));
		rows.push_back(mk_row(mk_cmd(OP_LOOKUP, 0, 0, 0, 5, 0), 1,
			mk_resp(ST_NOTFOUND, 0, 0, 0, 0, 0)));
		rows.push_back(mk_row(mk_cmd(OP_REMOVE, 0, 0, 0, 0, 10), 1,
			mk_resp(ST_NONE, 0, 0, 0, 0, 0)));
		rows.push_back(mk_row(mk_cmd(OP_ADD, 32'hA5A5_5A5A, 100, 100, 0, 0), 1,
			mk_resp(ST_NOBLK, 32'hA5A5_5A5A, 100, 100, 0, 0)));
		rows.push_back(mk_row(mk_cmd(OP_ADD, 32'hFFFF_FFFF, 5000, 10, 0, 0), 1,
			mk_resp(ST_NOBLK, 32'hFFFF_FFFF, 5000, 10, 0, 0)));
		rows.push_back(mk_row(mk_cmd(OP_ADD, 0, 4000, 5000, 0, 0), 1,
			mk_resp(ST_NOBLK, 0, 4000, 5000, 0, 0)));
		rows.push_back(mk_row(mk_cmd(OP_ADD, 32'h1111_0001, 0, 8192, 0, 0), 0, none));
		rows.push_back(mk_row(mk_cmd(OP_ADD, 32'hFFFF_FFFF, 48'hFFFF_FFFF_0000,
			48'hFFFF_FFFF_FFFF, 0, 0), 0, none));
		rows.push_back(mk_row(mk_cmd(OP_LOOKUP, 0, 0, 0, 0, 0), 0, none));
		rows.push_back(mk_row(mk_cmd(OP_LOOKUP, 0, 0, 0, 1, 0), 0, none));
		rows.push_back(mk_row(mk_cmd(OP_LOOKUP, 0, 0, 0, 16, 0), 0, none));
		rows.push_back(mk_row(mk_cmd(OP_LOOKUP, 0, 0, 0, 17, 0), 0, none));
		rows.push_back(mk_row(mk_cmd(OP_REMOVE, 0, 0, 0, 5, 7), 0, none));
		rows.push_back(mk_row(mk_cmd(OP_REMOVE, 0, 0, 0, 1, 4), 0, none));
		rows.push_back(mk_row(mk_cmd(OP_REMOVE, 0, 0, 0, 9, 3), 0, none));
		rows.push_back(mk_row(mk_cmd(OP_REMOVE, 0, 0, 0, 8, 8), 0, none));
		rows.push_back(mk_row(mk_cmd(OP_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF, 0), 0, none));
		rows.push_back(mk_row(mk_cmd(OP_COUNT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
			48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, none));
		rows.push_back(mk_row(mk_cmd(OP_REMOVE, 0, 0, 0, 0, 32'hFFFF_FFFF), 0, none));
		rows.push_back(mk_row(mk_cmd(OP_ADD, 1, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
			0, 0), 0, none));
		rows.push_back(mk_row(mk_cmd(OP_COUNT, 0, 0, 0, 0, 0), 0, none));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (rows[i]) begin
			send(rows[i].c, pick_gap());
			if (rows[i].typed) begin
				void'(pending_q.pop_back());
				rows[i].r.total = mapped;
				pending_q.push_back(rows[i].r);
			end
		end

		// random phases over several block sizes
		for (int p = 0; p < 8; p++) begin
			set_bsize(sizes[p % 5]);
			calm = (p == 3);
			for (int k = 0; k < 48; k++) begin
				if (p == 2 && k == 10) hold_req = 400;
				if (p == 5 && k == 20) begin
					drop_valid();
					wait (pending_q.size() == 0);
				end
				send(rand_cmd(), pick_gap());
			end
		end
		calm = 0;

		// fill the table, then hit the full cases and a maximal remove
		set_bsize(4096);
		send(mk_cmd(OP_REMOVE, 0, 0, 0, 0, 32'hFFFF_FFFF), pick_gap());
		for (int k = 0; k < 17; k++)
			send(mk_cmd(OP_ADD, $urandom, 48'(k) << 20, (48'(k) << 20) + 3 * 4096, 0, 0),
				pick_gap());
		send(mk_cmd(OP_REMOVE, 0, 0, 0, next_id - 2, next_id - 1), pick_gap());
		send(mk_cmd(OP_REMOVE, 0, 0, 0, 0, 32'hFFFF_FFFF), pick_gap());

		// exhaust the block id space
		set_bsize(1);
		send(mk_cmd(OP_ADD, $urandom, 0, 48'hFFFF_FFFF_FFFF, 0, 0), pick_gap());
		send(mk_cmd(OP_ADD, $urandom, 0, 48'hFFFF, 0, 0), pick_gap());
		send(mk_cmd(OP_LOOKUP, 0, 0, 0, 32'hFFFF_FFFE, 0), pick_gap());
		send(mk_cmd(OP_COUNT, 0, 0, 0, 0, 0), pick_gap());

		drain();
		repeat (40) @(posedge clk);
		if (!failed && pending_q.size() == 0)
			$display("** block_range_translation_table_unit: PASSED **");
		else
			$display("** block_range_translation_table_unit: FAILED **");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/brtt_pkg.sv
rtl/brtt_ram.sv
rtl/brtt_div.sv
rtl/brtt_mac.sv
rtl/block_range_translation_table_unit.sv
tb/tb.sv
